### src/scm_pkg.sv
// ----------------------------------------------------------------------------
// scm_pkg
// Shared types, command codes and helpers of the SPI command memory slave.
// ----------------------------------------------------------------------------
`default_nettype none

package scm_pkg;

  // Default size of the byte memory.
  localparam int DEFAULT_MEM_BYTES = 262144;

  // Depth of the queue between the command front and the memory back.
  localparam int QUEUE_DEPTH = 4;

  // Command codes: reads and writes with a 24-bit or a 16-bit address.
  localparam logic [7:0] OPC_RD24 = 8'hca;
  localparam logic [7:0] OPC_WR24 = 8'hc9;
  localparam logic [7:0] OPC_RD16 = 8'hc4;
  localparam logic [7:0] OPC_WR16 = 8'hc3;

  // Status codes.
  localparam logic [7:0] STATUS_OK    = 8'h00;
  localparam logic [7:0] STATUS_ERROR = 8'hFF;

  // Work handed from the front to the back.
  typedef enum logic [1:0] {
    OP_ECHO,
    OP_READ,
    OP_WRITE,
    OP_ERROR
  } op_kind_e;

  typedef struct packed {
    op_kind_e    kind;
    logic        in_range;
    logic [23:0] addr;
    logic [31:0] wdata;     // write data, or the echoed command in the low byte
  } op_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_RUN,
    BK_EMIT
  } bk_state_e;

  typedef struct packed {
    logic clearing;
  } bk_status_t;

  // Number of address bytes that follow a command.
  function automatic logic [3:0] addr_len(input logic [7:0] cmd);
    logic [3:0] len;
    len = 4'd0;
    if (cmd == OPC_RD24 || cmd == OPC_WR24) begin
      len = 4'd3;
    end else if (cmd == OPC_RD16 || cmd == OPC_WR16) begin
      len = 4'd2;
    end
    return len;
  endfunction

  // Number of bytes in all that follow a command.
  function automatic logic [3:0] total_len(input logic [7:0] cmd);
    logic [3:0] len;
    len = 4'd8;
    if (cmd == OPC_RD24) begin
      len = 4'd3;
    end else if (cmd == OPC_RD16) begin
      len = 4'd2;
    end else if (cmd == OPC_WR24) begin
      len = 4'd7;
    end else if (cmd == OPC_WR16) begin
      len = 4'd6;
    end
    return len;
  endfunction

  // Byte of a 32-bit word, the first received byte at index zero.
  function automatic logic [7:0] word_lane(input logic [31:0] w, input logic [1:0] sel);
    logic [7:0] res;
    unique case (sel)
      2'd0: res = w[31:24];
      2'd1: res = w[23:16];
      2'd2: res = w[15:8];
      default: res = w[7:0];
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

### src/scm_ram.sv
// ----------------------------------------------------------------------------
// scm_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(DEPTH)-1:0] waddr_i,
  input  wire [WIDTH-1:0]         wdata_i,
  input  wire                     re_i,
  input  wire [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### src/scm_front.sv
// ----------------------------------------------------------------------------
// scm_front
// Accepts received words, tracks the command framing and queues work.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_front #(
  parameter int MEM_BYTES = scm_pkg::DEFAULT_MEM_BYTES
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 rx_valid_i,
  input  wire [7:0]           rx_byte_i,
  output logic                rx_stall_o,
  input  scm_pkg::bk_status_t status_i,
  input  wire                 full_i,
  output logic                push_o,
  output scm_pkg::op_t        op_o
);

  localparam logic [24:0] Limit = 25'(MEM_BYTES - 4);

  logic        phase_q, phase_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [23:0] addr_q, addr_d;
  logic [31:0] data_q, data_d;

  logic        accept;
  logic [3:0]  cnt_nx;
  logic [23:0] addr_nx;
  logic [31:0] data_nx;
  logic        done;

  assign rx_stall_o = full_i | status_i.clearing;
  assign accept     = rx_valid_i & ~rx_stall_o;

  always_comb begin
    cnt_nx  = cnt_q + 4'd1;
    addr_nx = addr_q;
    data_nx = data_q;
    if (cnt_q < scm_pkg::addr_len(cmd_q)) begin
      addr_nx = {addr_q[15:0], rx_byte_i};
    end else begin
      data_nx = {data_q[23:0], rx_byte_i};
    end
    done = (cnt_nx == scm_pkg::total_len(cmd_q));
  end

  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    cnt_d   = cnt_q;
    addr_d  = addr_q;
    data_d  = data_q;
    push_o  = 1'b0;
    op_o.kind     = scm_pkg::OP_ECHO;
    op_o.in_range = ({1'b0, addr_nx} < Limit);
    op_o.addr     = addr_nx;
    op_o.wdata    = {24'd0, rx_byte_i};
    if (accept) begin
      if (!phase_q) begin
        // Command word: echo it and start collecting.
        push_o  = 1'b1;
        phase_d = 1'b1;
        cmd_d   = rx_byte_i;
        cnt_d   = 4'd0;
        addr_d  = 24'd0;
        data_d  = 32'd0;
      end else begin
        cnt_d  = cnt_nx;
        addr_d = addr_nx;
        data_d = data_nx;
        if (done) begin
          push_o     = 1'b1;
          phase_d    = 1'b0;
          cnt_d      = 4'd0;
          op_o.wdata = data_nx;
          if (cmd_q == scm_pkg::OPC_RD24 || cmd_q == scm_pkg::OPC_RD16) begin
            op_o.kind = scm_pkg::OP_READ;
          end else if (cmd_q == scm_pkg::OPC_WR24 || cmd_q == scm_pkg::OPC_WR16) begin
            op_o.kind = scm_pkg::OP_WRITE;
          end else begin
            op_o.kind = scm_pkg::OP_ERROR;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      cmd_q   <= 8'd0;
      cnt_q   <= 4'd0;
      addr_q  <= 24'd0;
      data_q  <= 32'd0;
    end else begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      cnt_q   <= cnt_d;
      addr_q  <= addr_d;
      data_q  <= data_d;
    end
  end

endmodule

`default_nettype wire

### src/scm_queue.sv
// ----------------------------------------------------------------------------
// scm_queue
// Short first-in first-out queue of work between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_queue (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          push_i,
  input  scm_pkg::op_t data_i,
  output logic         full_o,
  input  wire          pop_i,
  output scm_pkg::op_t data_o,
  output logic         valid_o
);

  localparam int PtrW = $clog2(scm_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(scm_pkg::QUEUE_DEPTH + 1);

  scm_pkg::op_t    entry_q [scm_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == CntW'(scm_pkg::QUEUE_DEPTH));
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### src/scm_back.sv
// ----------------------------------------------------------------------------
// scm_back
// Carries out queued work on the four-bank byte memory and drives the output.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_back #(
  parameter int MEM_BYTES = scm_pkg::DEFAULT_MEM_BYTES
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  scm_pkg::op_t        head_i,
  input  wire                 head_valid_i,
  output logic                pop_o,
  output scm_pkg::bk_status_t status_o,
  output logic                tx_valid_o,
  input  wire                 tx_stall_i,
  output logic [7:0]          tx_byte_o,
  output logic                eot_o
);

  localparam int BankDepth = (MEM_BYTES + 3) / 4;
  localparam int RowW      = $clog2(BankDepth);

  scm_pkg::bk_state_e state_q, state_d;

  logic [RowW-1:0] clr_row_q;
  logic            clr_last;
  logic [1:0]      idx_q;
  logic [1:0]      lane_q;
  logic            ok_q;

  logic            out_free;
  logic            out_ld;
  logic [7:0]      out_byte;
  logic            out_eot;
  logic            rd_issue;
  logic            wr_issue;
  logic            clr_we;

  logic [7:0]      rdata [4];
  logic [1:0]      emit_bank;

  assign out_free = ~tx_valid_o | ~tx_stall_i;
  assign clr_last = (clr_row_q == RowW'(BankDepth - 1));
  assign emit_bank = lane_q + idx_q;
  assign status_o.clearing = (state_q == scm_pkg::BK_CLEAR);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      scm_pkg::BK_CLEAR: begin
        if (clr_last) begin
          state_d = scm_pkg::BK_RUN;
        end
      end
      scm_pkg::BK_RUN: begin
        if (head_valid_i && head_i.kind == scm_pkg::OP_READ) begin
          state_d = scm_pkg::BK_EMIT;
        end
      end
      scm_pkg::BK_EMIT: begin
        if (out_free && idx_q == 2'd3) begin
          state_d = scm_pkg::BK_RUN;
        end
      end
      default: state_d = scm_pkg::BK_CLEAR;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    pop_o    = 1'b0;
    out_ld   = 1'b0;
    out_byte = scm_pkg::STATUS_OK;
    out_eot  = 1'b1;
    rd_issue = 1'b0;
    wr_issue = 1'b0;
    clr_we   = 1'b0;
    unique case (state_q)
      scm_pkg::BK_CLEAR: begin
        clr_we = 1'b1;
      end
      scm_pkg::BK_RUN: begin
        if (head_valid_i) begin
          unique case (head_i.kind)
            scm_pkg::OP_READ: begin
              pop_o    = 1'b1;
              rd_issue = 1'b1;
            end
            scm_pkg::OP_ECHO: begin
              pop_o    = out_free;
              out_ld   = out_free;
              out_byte = head_i.wdata[7:0];
              out_eot  = 1'b0;
            end
            scm_pkg::OP_WRITE: begin
              pop_o    = out_free;
              out_ld   = out_free;
              wr_issue = out_free & head_i.in_range;
              out_byte = scm_pkg::STATUS_OK;
            end
            scm_pkg::OP_ERROR: begin
              pop_o    = out_free;
              out_ld   = out_free;
              out_byte = scm_pkg::STATUS_ERROR;
            end
            default: begin
              pop_o = 1'b0;
            end
          endcase
        end
      end
      scm_pkg::BK_EMIT: begin
        out_ld   = out_free;
        out_byte = ok_q ? rdata[emit_bank] : 8'd0;
        out_eot  = (idx_q == 2'd3);
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  // Four byte banks: byte address a lives in bank a[1:0], row a[..:2]. An
  // unaligned access wraps into the next row for banks below the start lane.
  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [1:0]      sel;
    logic [RowW-1:0] row;
    logic [RowW-1:0] addr;
    logic            we;
    logic [7:0]      wdata;

    assign sel   = 2'(k) - head_i.addr[1:0];
    assign row   = head_i.addr[RowW+1:2] + RowW'(2'(k) < head_i.addr[1:0]);
    assign addr  = clr_we ? clr_row_q : row;
    assign we    = clr_we | wr_issue;
    assign wdata = clr_we ? 8'd0 : scm_pkg::word_lane(head_i.wdata, sel);

    scm_ram #(
      .WIDTH(8),
      .DEPTH(BankDepth)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (addr),
      .wdata_i (wdata),
      .re_i    (rd_issue),
      .raddr_i (row),
      .rdata_o (rdata[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= scm_pkg::BK_CLEAR;
      clr_row_q  <= '0;
      idx_q      <= 2'd0;
      tx_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clr_we) begin
        clr_row_q <= clr_row_q + RowW'(1);
      end
      if (rd_issue) begin
        idx_q <= 2'd0;
      end else if (state_q == scm_pkg::BK_EMIT && out_free) begin
        idx_q <= idx_q + 2'd1;
      end
      if (out_free) begin
        tx_valid_o <= out_ld;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_issue) begin
      lane_q <= head_i.addr[1:0];
      ok_q   <= head_i.in_range;
    end
    if (out_ld) begin
      tx_byte_o <= out_byte;
      eot_o     <= out_eot;
    end
  end

endmodule

`default_nettype wire

### src/spi_command_memory_slave.sv
// A command echo passes the work queue and then the output register; the first read data
// word passes the queue, the registered RAM read and the output register, and the other
// three follow. Throughput: one received word per cycle unless rx_stall_o is high, one
// output word per cycle unless tx_stall_i is high; a read issues its RAM read in a state
// that loads no output word. Reset: asynchronous, active low. After reset the memory is
// cleared, one row of all four banks per cycle, while rx_stall_o is held high.
// ----------------------------------------------------------------------------
// spi_command_memory_slave
// SPI command decoder with a byte-addressed memory behind it.
// ----------------------------------------------------------------------------
`default_nettype none

// The front end takes each received word, echoes command words and collects the
// big-endian address and the data words of a command. When a command is complete it
// posts one work entry into a short queue. The back end pops that queue, does the
// memory access on four byte-wide banks, so that an unaligned four-byte access needs one
// access per bank, and feeds an output register. The queue and the output register let
// both ends stall independently: until the queue is full, a new word is accepted while
// earlier responses still wait on the output.
//
// Accesses are in range only below MEM_BYTES - 4. An out-of-range read returns four zero
// words and an out-of-range write is dropped but still answers with the OK status.
// Unknown commands swallow eight words and answer with the error status.
module spi_command_memory_slave #(
  parameter int MEM_BYTES = scm_pkg::DEFAULT_MEM_BYTES
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        rx_valid_i,
  output logic       rx_stall_o,
  input  wire [7:0]  rx_byte_i,
  output logic       tx_valid_o,
  input  wire        tx_stall_i,
  output logic [7:0] tx_byte_o,
  output logic       end_of_transaction_o
);

  scm_pkg::bk_status_t status;
  scm_pkg::op_t        push_op;
  scm_pkg::op_t        head_op;
  logic                push;
  logic                full;
  logic                pop;
  logic                head_valid;

  // Front: command framing and classification.
  scm_front #(
    .MEM_BYTES(MEM_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_byte_i  (rx_byte_i),
    .rx_stall_o (rx_stall_o),
    .status_i   (status),
    .full_i     (full),
    .push_o     (push),
    .op_o       (push_op)
  );

  // Work queue between the two ends.
  scm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_op),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_op),
    .valid_o (head_valid)
  );

  // Back: memory access and response words.
  scm_back #(
    .MEM_BYTES(MEM_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_op),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .status_o     (status),
    .tx_valid_o   (tx_valid_o),
    .tx_stall_i   (tx_stall_i),
    .tx_byte_o    (tx_byte_o),
    .eot_o        (end_of_transaction_o)
  );

endmodule

`default_nettype wire

### src/scm_checker.sv
// ----------------------------------------------------------------------------
// scm_checker
// Port-level checks of the SPI command memory slave, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       rx_valid_i,
  input wire       rx_stall_o,
  input wire [7:0] rx_byte_i,
  input wire       tx_valid_o,
  input wire       tx_stall_i,
  input wire [7:0] tx_byte_o,
  input wire       end_of_transaction_o
);

  logic seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (rx_valid_i && !rx_stall_o) begin
      seen_q <= 1'b1;
    end
  end

  // The memory clearing pass starts right out of reset, with no response pending.
  a_clear_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> rx_stall_o && !tx_valid_o)
    else $error("input not stalled or output valid right after reset");

  // A response word never shows up before any received word was taken.
  a_no_spurious_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_o |-> seen_q)
    else $error("response word without any received word");

  // A stalled response word holds.
  a_tx_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_o && tx_stall_i |=> tx_valid_o && $stable(tx_byte_o) &&
                                 $stable(end_of_transaction_o))
    else $error("stalled response word changed");

  // A stalled received word holds until it is taken.
  a_rx_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_valid_i && rx_stall_o |=> rx_valid_i && $stable(rx_byte_i))
    else $error("stalled received word changed");

endmodule

bind spi_command_memory_slave scm_checker u_scm_checker (.*);

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the SPI command memory slave. Received words are
// driven through the rx handshake as whole command transactions, a bench-side
// model of the decoder and of the byte memory predicts every response word,
// and a receiver process compares each accepted tx word with the oldest
// prediction. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  // The memory keeps its default size, so the bounds test sits at 0x03FFFC.
  localparam int MEM_BYTES   = scm_pkg::DEFAULT_MEM_BYTES;
  localparam int CYCLE_LIMIT = 500000;
  // Cycles to keep watching the output once nothing is expected any more.
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_WORDS = 450;

  typedef enum logic {
    AWAIT_COMMAND,
    GATHER_BYTES
  } rx_phase_e;

  // One response word as the block should present it.
  typedef struct {
    logic [7:0] tx_byte;
    logic       eot;
  } tx_word_t;

  logic       clk_i;
  logic       rst_ni;
  logic       rx_valid_i;
  logic       rx_stall_o;
  logic [7:0] rx_byte_i;
  logic       tx_valid_o;
  logic       tx_stall_i;
  logic [7:0] tx_byte_o;
  logic       end_of_transaction_o;

  spi_command_memory_slave #(
    .MEM_BYTES(MEM_BYTES)
  ) DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .rx_valid_i          (rx_valid_i),
    .rx_stall_o          (rx_stall_o),
    .rx_byte_i           (rx_byte_i),
    .tx_valid_o          (tx_valid_o),
    .tx_stall_i          (tx_stall_i),
    .tx_byte_o           (tx_byte_o),
    .end_of_transaction_o(end_of_transaction_o)
  );

  // Bench copy of the decoder state and of the byte memory. The memory is
  // two-state, so it starts out as all zeros, just like the cleared RAM.
  bit [7:0]    mem_image [0:MEM_BYTES-1];
  rx_phase_e   rx_phase   = AWAIT_COMMAND;
  logic [7:0]  open_cmd   = '0;
  logic [3:0]  bytes_seen = '0;
  logic [23:0] addr_acc   = '0;
  logic [31:0] wdata_acc  = '0;

  // Response words that the block still owes, oldest first.
  tx_word_t tx_pending [$];

  int  error_count = 0;
  int  words_sent  = 0;
  int  cycle_count = 0;
  // While one of these is set, that side of the bench neither idles nor stalls.
  bit  rx_steady   = 1'b0;
  bit  tx_steady   = 1'b0;

  // --------------------------------------------------------------------------
  // Clock, reset and the cycle limit.
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // A run that is stuck (a lost word, a stall that never drops) ends here.
  // The limit covers the clearing pass after reset plus several times the
  // slowest legal run of all the stimulus.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Prediction.
  // --------------------------------------------------------------------------

  // Address bytes that follow a command byte.
  function automatic int address_bytes(input logic [7:0] cmd);
    if (cmd == scm_pkg::OPC_RD24 || cmd == scm_pkg::OPC_WR24) begin
      return 3;
    end
    if (cmd == scm_pkg::OPC_RD16 || cmd == scm_pkg::OPC_WR16) begin
      return 2;
    end
    return 0;
  endfunction

  function automatic bit is_read(input logic [7:0] cmd);
    return cmd == scm_pkg::OPC_RD24 || cmd == scm_pkg::OPC_RD16;
  endfunction

  function automatic bit is_write(input logic [7:0] cmd);
    return cmd == scm_pkg::OPC_WR24 || cmd == scm_pkg::OPC_WR16;
  endfunction

  // All bytes that follow a command byte: the address plus four data bytes
  // for a write, and eight bytes that are thrown away for anything unknown.
  function automatic int trailing_bytes(input logic [7:0] cmd);
    if (is_read(cmd)) return address_bytes(cmd);
    if (is_write(cmd)) return address_bytes(cmd) + 4;
    return 8;
  endfunction

  // Advances the bench model by one received word and queues the response
  // words that it causes. The bounds test is kept exactly as the block has
  // it: an access that starts in the top four bytes of memory is out of range.
  function automatic void predict_response(input logic [7:0] b);
    tx_word_t w;
    bit       reachable;
    if (rx_phase == AWAIT_COMMAND) begin
      open_cmd   = b;
      bytes_seen = '0;
      addr_acc   = '0;
      wdata_acc  = '0;
      rx_phase   = GATHER_BYTES;
      w.tx_byte  = b;
      w.eot      = 1'b0;
      tx_pending.push_back(w);
      return;
    end
    if (int'(bytes_seen) < address_bytes(open_cmd)) begin
      addr_acc = {addr_acc[15:0], b};
    end else begin
      wdata_acc = {wdata_acc[23:0], b};
    end
    bytes_seen = bytes_seen + 4'd1;
    if (int'(bytes_seen) < trailing_bytes(open_cmd)) return;

    rx_phase   = AWAIT_COMMAND;
    bytes_seen = '0;
    reachable  = int'(addr_acc) < MEM_BYTES - 4;
    if (is_read(open_cmd)) begin
      for (int i = 0; i < 4; i++) begin
        w.tx_byte = reachable ? mem_image[int'(addr_acc) + i] : 8'h00;
        w.eot     = (i == 3);
        tx_pending.push_back(w);
      end
    end else if (is_write(open_cmd)) begin
      if (reachable) begin
        for (int i = 0; i < 4; i++) begin
          mem_image[int'(addr_acc) + i] = wdata_acc[31 - 8 * i -: 8];
        end
      end
      w.tx_byte = scm_pkg::STATUS_OK;
      w.eot     = 1'b1;
      tx_pending.push_back(w);
    end else begin
      w.tx_byte = scm_pkg::STATUS_ERROR;
      w.eot     = 1'b1;
      tx_pending.push_back(w);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sending side.
  // --------------------------------------------------------------------------

  // Offers one word after a random idle gap and returns in the time step of
  // the edge that accepts it. Valid stays high from one word to the next when
  // there is no gap, so it is never dropped and raised in the same step.
  task automatic send_word(input logic [7:0] b);
    int gap;
    gap = rx_steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      rx_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    // The stall seen here is the value from before the edge, so the test for
    // acceptance does not depend on the order of processes in this step.
    do @(posedge clk_i); while (rx_stall_o);
    predict_response(b);
    words_sent++;
  endtask

  // Sends one whole transaction: the command word, its big-endian address
  // and its data words. Unknown commands get eight random trailing words.
  task automatic send_command(input logic [7:0] cmd, input logic [23:0] addr,
                              input logic [31:0] data);
    int n_addr;
    n_addr = address_bytes(cmd);
    send_word(cmd);
    for (int i = n_addr - 1; i >= 0; i--) begin
      send_word(addr[8 * i +: 8]);
    end
    if (is_write(cmd)) begin
      for (int i = 3; i >= 0; i--) begin
        send_word(data[8 * i +: 8]);
      end
    end else if (!is_read(cmd)) begin
      repeat (8) send_word(8'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiving side: stalls for a random number of cycles before each word,
  // then takes the word and checks it against the oldest prediction.
  // --------------------------------------------------------------------------
  initial begin
    tx_word_t want;
    int       hold;
    tx_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = tx_steady ? 0 : $urandom_range(0, 10);
      if (hold > 0) begin
        tx_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      tx_stall_i <= 1'b0;
      do @(posedge clk_i); while (!tx_valid_o);
      if (tx_pending.size() == 0) begin
        $error("tx word 0x%02h with no response pending", tx_byte_o);
        error_count++;
      end else begin
        want = tx_pending.pop_front();
        if (tx_byte_o !== want.tx_byte) begin
          $error("tx_byte: expected 0x%02h, got 0x%02h", want.tx_byte, tx_byte_o);
          error_count++;
        end
        if (end_of_transaction_o !== want.eot) begin
          $error("end_of_transaction: expected %0b, got %0b", want.eot,
                 end_of_transaction_o);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // The last reachable address takes a write, the first unreachable one
  // drops its write, and reads on both sides of the limit show the result.
  // The reads run with no idling so that responses pile up on the output.
  task automatic test_range_bounds();
    send_command(scm_pkg::OPC_WR24, 24'(MEM_BYTES - 5), 32'hFF00A55A);
    send_command(scm_pkg::OPC_WR24, 24'(MEM_BYTES - 4), 32'h11223344);
    rx_steady = 1'b1;
    send_command(scm_pkg::OPC_RD24, 24'(MEM_BYTES - 5), '0);
    send_command(scm_pkg::OPC_RD24, 24'hFFFFFF, '0);
    rx_steady = 1'b0;
  endtask

  // The short-address commands at the top of their address space, and an
  // unknown command that answers with the error status.
  task automatic test_internal_and_unknown();
    send_command(scm_pkg::OPC_WR16, 24'h00FFFF, 32'h0102FE7F);
    send_command(scm_pkg::OPC_RD16, 24'h00FFFF, '0);
    send_command(8'h00, '0, '0);
  endtask

  // Address for a random transaction. Half or more land in a small window so
  // that reads find earlier writes, some 24-bit ones straddle the top limit,
  // and the rest are spread over the whole field of their width.
  function automatic logic [23:0] pick_address(input bit short_addr);
    int r;
    r = $urandom_range(0, 9);
    if (short_addr) begin
      return (r < 7) ? 24'($urandom_range(0, 63)) : 24'($urandom_range(0, 65535));
    end
    if (r < 5) return 24'($urandom_range(0, 63));
    if (r < 7) return 24'(MEM_BYTES - $urandom_range(1, 12));
    return 24'($urandom);
  endfunction

  // Well-formed transactions with random commands, addresses and data.
  // Unknown commands with random trailing words serve as the noise. Each
  // side now and then switches between idling at random and running flat out.
  task automatic test_random_traffic();
    logic [7:0] cmd;
    int         r;
    while (words_sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 9) == 0) rx_steady = ~rx_steady;
      if ($urandom_range(0, 9) == 0) tx_steady = ~tx_steady;
      r = $urandom_range(0, 19);
      if (r < 6) begin
        cmd = scm_pkg::OPC_WR24;
      end else if (r < 9) begin
        cmd = scm_pkg::OPC_WR16;
      end else if (r < 14) begin
        cmd = scm_pkg::OPC_RD24;
      end else if (r < 17) begin
        cmd = scm_pkg::OPC_RD16;
      end else begin
        do cmd = 8'($urandom); while (is_read(cmd) || is_write(cmd));
      end
      send_command(cmd, pick_address(address_bytes(cmd) == 2), $urandom);
    end
    rx_steady = 1'b0;
    tx_steady = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence of the run.
  // --------------------------------------------------------------------------
  initial begin
    rst_ni     <= 1'b0;
    rx_valid_i <= 1'b0;
    rx_byte_i  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_range_bounds();
    test_internal_and_unknown();
    test_random_traffic();
    rx_valid_i <= 1'b0;

    // Let the last responses drain, then watch a little longer for any
    // word the block sends beyond what was predicted.
    while (tx_pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
